// ===== design/clhd_pkg.sv =====
// Package for the Content-Length header deframer.
// Holds the line kinds, the parser state word and the byte constants.
// No dependencies.
package clhd_pkg;

    localparam int LEN_W = 31;
    localparam int ACC_W = LEN_W + 4;
    localparam int POS_W = 5;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [POS_W-1:0] PREFIX_LEN = 5'd16;
    localparam logic [POS_W-1:0] POS_IN_VALUE = 5'd17;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_OTHER = 2'd2
    } line_kind_t;

    typedef struct packed {
        logic             cr_pending;
        logic             line_is_empty;
        logic [POS_W-1:0] prefix_position;
        line_kind_t       line_kind;
        logic             value_negative;
        logic             digit_seen;
        logic             value_invalid;
        logic [LEN_W-1:0] value_accumulator;
        logic [LEN_W-1:0] pending_length;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        cr_pending:        1'b0,
        line_is_empty:     1'b1,
        prefix_position:   '0,
        line_kind:         KIND_MATCH,
        value_negative:    1'b0,
        digit_seen:        1'b0,
        value_invalid:     1'b0,
        value_accumulator: '0,
        pending_length:    '0
    };

    // "Content-Length: "
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            4'd15:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/clhd_in_if.sv =====
// Input channel of the header deframer: one stream byte per word.
// Depends on nothing.
interface clhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source(output valid, data_byte, end_of_input, input ready);
    modport sink(input valid, data_byte, end_of_input, output ready);
endinterface

// ===== design/clhd_out_if.sv =====
// Result channel of the header deframer: one length and status per word.
// Depends on clhd_pkg.
interface clhd_out_if import clhd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] content_length;
    logic             status;

    modport source(output valid, content_length, status, input ready);
    modport sink(input valid, content_length, status, output ready);
endinterface

// ===== design/content_length_header_deframer.sv =====
// Content-Length header deframer: parses header lines, emits body length.
// Path: an accepted byte is held in the input reg, then any result it yields goes to the result reg.
// Throughput: one byte per cycle; stalls only while the result reg holds a word
// that is not taken in that cycle.
// Reset (rst_n low, asynchronous): parser state to start of message, no
// word held in the input or result register.
// Depends on clhd_pkg, clhd_in_if, clhd_out_if.
module content_length_header_deframer
    import clhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    clhd_in_if.sink     stream,
    clhd_out_if.source  result
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eoi_reg;

    parse_state_t     state_reg;
    parse_state_t     state_next;

    logic             res_valid_reg;
    logic [LEN_W-1:0] res_length_reg;
    logic             res_status_reg;

    logic             fire;
    logic             emit;
    logic [LEN_W-1:0] emit_length;
    logic             emit_status;

    function automatic parse_state_t take_content(input parse_state_t s,
                                                  input logic [7:0] c);
        parse_state_t     r;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] v;
        logic [7:0]       digit;
        logic             first;
        r = s;
        acc = {4'b0, s.value_accumulator};
        digit = c - CH_ZERO;
        v = (acc << 3) + (acc << 1) + {{(ACC_W-8){1'b0}}, digit};
        first = (s.prefix_position == PREFIX_LEN);
        r.line_is_empty = 1'b0;
        if (s.line_kind != KIND_OTHER)
        begin
            if (c == CH_NUL)
            begin
                r.line_kind = KIND_OTHER;
            end
            else if (s.line_kind == KIND_MATCH)
            begin
                if (s.prefix_position < PREFIX_LEN
                        && c == prefix_char(s.prefix_position[3:0]))
                begin
                    r.prefix_position = s.prefix_position + 5'd1;
                    if (s.prefix_position == PREFIX_LEN - 5'd1)
                    begin
                        r.line_kind = KIND_VALUE;
                    end
                end
                else
                begin
                    r.line_kind = KIND_OTHER;
                end
            end
            else
            begin
                r.prefix_position = POS_IN_VALUE;
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    r.digit_seen = 1'b1;
                    if (!s.value_invalid)
                    begin
                        if (v > {4'b0, LEN_MAX})
                        begin
                            r.value_invalid = 1'b1;
                        end
                        else
                        begin
                            r.value_accumulator = v[LEN_W-1:0];
                        end
                    end
                end
                else if (first && (c == CH_PLUS || c == CH_MINUS))
                begin
                    if (c == CH_MINUS)
                    begin
                        r.value_negative = 1'b1;
                    end
                end
                else
                begin
                    r.value_invalid = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign fire = in_valid_reg && (!res_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || fire;

    always_comb
    begin
        logic             lf_done;
        logic [LEN_W-1:0] pend;
        state_next = state_reg;
        emit = 1'b0;
        emit_length = '0;
        emit_status = 1'b0;
        lf_done = 1'b0;
        pend = state_reg.pending_length;
        if (in_eoi_reg)
        begin
            emit = 1'b1;
            emit_status = 1'b1;
            state_next = STATE_RESET;
        end
        else
        begin
            if (state_reg.cr_pending)
            begin
                state_next.cr_pending = 1'b0;
                if (in_byte_reg == CH_LF)
                begin
                    lf_done = 1'b1;
                    if (state_reg.line_is_empty)
                    begin
                        emit = 1'b1;
                        emit_length = state_reg.pending_length;
                        state_next = STATE_RESET;
                    end
                    else
                    begin
                        if (state_reg.line_kind == KIND_VALUE)
                        begin
                            if (!state_reg.value_invalid && state_reg.digit_seen
                                    && !state_reg.value_negative)
                            begin
                                pend = state_reg.value_accumulator;
                            end
                            else
                            begin
                                pend = '0;
                            end
                        end
                        state_next = STATE_RESET;
                        state_next.pending_length = pend;
                    end
                end
                else
                begin
                    state_next = take_content(state_next, CH_CR);
                end
            end
            if (!lf_done)
            begin
                if (in_byte_reg == CH_CR)
                begin
                    state_next.cr_pending = 1'b1;
                end
                else
                begin
                    state_next = take_content(state_next, in_byte_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (fire)
            begin
                res_valid_reg <= emit;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.data_byte;
            in_eoi_reg <= stream.end_of_input;
        end
        if (fire && emit)
        begin
            res_length_reg <= emit_length;
            res_status_reg <= emit_status;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.content_length = res_length_reg;
    assign result.status = res_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.content_length == '0)
        else $error("error result carries a nonzero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.prefix_position <= POS_IN_VALUE)
        else $error("prefix position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line_kind == KIND_VALUE |-> state_reg.prefix_position >= PREFIX_LEN)
        else $error("value part entered before full prefix");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> state_reg.line_is_empty && !state_reg.cr_pending
                         && state_reg.pending_length == '0)
        else $error("state not cleared after a result");

endmodule

// ===== sim/content_length_header_deframer_checker.sv =====
`timescale 1ns / 1ps
// Checker for content_length_header_deframer: tracks the header parse of every
// accepted byte word and compares each result word with the predicted length and status.
// Depends on clhd_pkg, clhd_in_if and clhd_out_if.
module content_length_header_deframer_checker
    import clhd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    clhd_in_if   stream,
    clhd_out_if  result,
    output int   errors,
    output int   outstanding
);

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             status;
    } header_verdict_t;

    localparam logic [8*16-1:0] LENGTH_TAG = "Content-Length: ";

    header_verdict_t  verdict_q[$];
    logic             cr_seen;
    logic             line_blank;
    logic [POS_W-1:0] tag_pos;
    line_kind_t       kind;
    logic             minus_seen;
    logic             have_digit;
    logic             bad_value;
    logic [LEN_W-1:0] acc;
    logic [LEN_W-1:0] held_length;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic clear_line();
        cr_seen = 1'b0;
        line_blank = 1'b1;
        tag_pos = '0;
        kind = KIND_MATCH;
        minus_seen = 1'b0;
        have_digit = 1'b0;
        bad_value = 1'b0;
        acc = '0;
    endtask

    task automatic start_message();
        clear_line();
        held_length = '0;
    endtask

    task automatic take_line_char(input logic [7:0] c);
        logic        first;
        logic [63:0] sum;
        line_blank = 1'b0;
        if (kind != KIND_OTHER)
        begin
            if (c == CH_NUL)
                kind = KIND_OTHER;
            else if (kind == KIND_MATCH)
            begin
                if (tag_pos < PREFIX_LEN && c == LENGTH_TAG[8*(15 - tag_pos[3:0]) +: 8])
                begin
                    tag_pos++;
                    if (tag_pos == PREFIX_LEN)
                        kind = KIND_VALUE;
                end
                else
                    kind = KIND_OTHER;
            end
            else
            begin
                first = (tag_pos == PREFIX_LEN);
                tag_pos = POS_IN_VALUE;
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    have_digit = 1'b1;
                    if (!bad_value)
                    begin
                        sum = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
                        if (sum > 64'(LEN_MAX))
                            bad_value = 1'b1;
                        else
                            acc = sum[LEN_W-1:0];
                    end
                end
                else if (first && (c == CH_PLUS || c == CH_MINUS))
                begin
                    if (c == CH_MINUS)
                        minus_seen = 1'b1;
                end
                else
                    bad_value = 1'b1;
            end
        end
    endtask

    task automatic parse_word(input logic [7:0] c, input logic eoi);
        header_verdict_t v;
        logic            line_done;
        line_done = 1'b0;
        if (eoi)
        begin
            v.length = '0;
            v.status = 1'b1;
            verdict_q.push_back(v);
            start_message();
        end
        else
        begin
            if (cr_seen)
            begin
                cr_seen = 1'b0;
                if (c == CH_LF)
                begin
                    line_done = 1'b1;
                    if (line_blank)
                    begin
                        v.length = held_length;
                        v.status = 1'b0;
                        verdict_q.push_back(v);
                        start_message();
                    end
                    else
                    begin
                        if (kind == KIND_VALUE)
                            held_length = (!bad_value && have_digit && !minus_seen) ? acc : '0;
                        clear_line();
                    end
                end
                else
                    take_line_char(CH_CR);
            end
            if (!line_done)
            begin
                if (c == CH_CR)
                    cr_seen = 1'b1;
                else
                    take_line_char(c);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        header_verdict_t want;
        if (!rst_n)
        begin
            verdict_q.delete();
            start_message();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                    flag_mismatch("result with none awaited", result.content_length, 0);
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.content_length !== want.length)
                        flag_mismatch("content_length", result.content_length, want.length);
                    if (result.status !== want.status)
                        flag_mismatch("status", result.status, want.status);
                end
            end
            if (stream.valid && stream.ready)
                parse_word(stream.data_byte, stream.end_of_input);
            outstanding = verdict_q.size();
        end
    end

endmodule

// ===== sim/content_length_header_deframer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for content_length_header_deframer: drives header byte streams
// under varying back-pressure and gives the verdict from the checker.
// Depends on clhd_pkg, clhd_in_if, clhd_out_if and the checker module.
module content_length_header_deframer_tb
    import clhd_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 850;

    typedef enum int {
        LK_DECIMAL,
        LK_LARGEST,
        LK_OVERFLOW,
        LK_NEGATIVE,
        LK_PLUS,
        LK_EMPTY,
        LK_SIGN_ONLY,
        LK_BAD_CHAR,
        LK_BROKEN_TAG,
        LK_NUL,
        LK_TRUNCATED,
        LK_OTHER,
        LK_COUNT
    } header_line_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    int         errors;
    int         outstanding;
    int         cycles = 0;
    int         src_gap;
    int         sink_gap;
    int         stall_left = 0;
    int         sent;
    int         messages;
    int         line_serial = 0;
    logic [7:0] line_bytes[$];

    clhd_in_if  stream();
    clhd_out_if result();

    content_length_header_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    content_length_header_deframer_checker verdict_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("content_length_header_deframer regression: fail");
            $finish;
        end
    end

    // hold off the receiver while a stall is counting down
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result.ready = 1'b0;
            stall_left--;
        end
        else
            result.ready = ($urandom_range(99) >= sink_gap);
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < src_gap)
        begin
            stream.valid = 1'b0;
            @(negedge clk);
        end
        stream.valid = 1'b1;
        stream.data_byte = b;
        stream.end_of_input = eoi;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_line_end();
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
    endtask

    task automatic append(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic drain();
        stream.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_header_line(input int kind);
        logic [LEN_W-1:0] len;
        logic [63:0]      big;
        string            digits;
        int               keep;
        case ($urandom_range(3))
            0:       len = LEN_W'($urandom_range(9));
            1:       len = LEN_W'($urandom_range(99999));
            2:       len = LEN_W'($urandom) & LEN_MAX;
            default: len = LEN_MAX - LEN_W'($urandom_range(3));
        endcase
        digits = $sformatf("%0d", len);
        line_bytes.delete();
        if (kind != LK_OTHER)
            append("Content-Length: ");
        case (kind)
            LK_DECIMAL:   append(digits);
            LK_LARGEST:
            begin
                if ($urandom_range(1))
                    append("000");
                append("2147483647");
            end
            LK_OVERFLOW:
            begin
                if ($urandom_range(1))
                    big = 64'd2147483648 + 64'($urandom_range(1000));
                else
                    big = {$urandom, $urandom} | 64'h1_0000_0000;
                append($sformatf("%0d", big));
            end
            LK_NEGATIVE:
            begin
                append("-");
                append($urandom_range(1) ? "0" : digits);
            end
            LK_PLUS:
            begin
                append("+");
                append(digits);
            end
            LK_EMPTY:     ;
            LK_SIGN_ONLY: append($urandom_range(1) ? "+" : "-");
            LK_BAD_CHAR:
            begin
                append(digits);
                line_bytes.insert($urandom_range(16, line_bytes.size()),
                                  8'($urandom_range(255)));
            end
            LK_BROKEN_TAG:
            begin
                append(digits);
                line_bytes[$urandom_range(15)] = 8'($urandom_range(255));
            end
            LK_NUL:
            begin
                append(digits);
                line_bytes.insert($urandom_range(line_bytes.size()), CH_NUL);
            end
            LK_TRUNCATED:
            begin
                keep = $urandom_range(1, 15);
                line_bytes = line_bytes[0:keep-1];
            end
            default:
            begin
                append("X-Trace: ");
                repeat ($urandom_range(8))
                    line_bytes.push_back(8'($urandom_range(32, 126)));
            end
        endcase
        foreach (line_bytes[i])
            send_word(line_bytes[i], 1'b0);
        send_line_end();
    endtask

    task automatic send_message();
        int kind;
        repeat ($urandom_range(2))
        begin
            if (line_serial < LK_COUNT)
                kind = line_serial;
            else if ($urandom_range(99) < 45)
                kind = LK_DECIMAL;
            else
                kind = $urandom_range(LK_COUNT - 1);
            line_serial++;
            send_header_line(kind);
        end
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 6))
                send_word(8'($urandom_range(255)), 1'b0);
            send_line_end();
        end
        if ($urandom_range(99) < 10)
            send_word(8'($urandom_range(255)), 1'b1);
        else
            send_line_end();
        messages++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        stream.valid = 1'b0;
        stream.data_byte = '0;
        stream.end_of_input = 1'b0;
        result.ready = 1'b0;
        src_gap = 11;
        sink_gap = 72;
        sent = 0;
        messages = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_line_end();
        send_word(8'hFF, 1'b1);
        send_word(CH_NUL, 1'b0);
        send_line_end();
        send_word(CH_CR, 1'b0);
        send_word("x", 1'b0);
        send_word(CH_LF, 1'b0);
        send_line_end();
        send_text("Con");
        send_line_end();
        send_line_end();
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b1);
        drain();

        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_gap = 11;
                    sink_gap = 72;
                end
                1:
                begin
                    src_gap = 72;
                    sink_gap = 11;
                end
                default:
                begin
                    src_gap = 0;
                    sink_gap = 0;
                    // back up the result path, then keep offering empty headers
                    stall_left = 300;
                    repeat (25)
                        send_line_end();
                    drain();
                end
            endcase
            while (sent < RANDOM_WORDS * (phase + 1) / 3)
                send_message();
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("content_length_header_deframer regression: pass");
        else
            $display("content_length_header_deframer regression: fail");
        $finish;
    end

endmodule
